// ----- hw/rtl/hlr_pkg.sv -----
// Shared constants and controller/datapath interface types for the histogram rectangle block.
package hlr_pkg;

  localparam int unsigned HEIGHT_W = 16;
  localparam int unsigned AREA_W   = 26;
  localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;     // latch a new bar request
    logic ovf;      // bar dropped, flag overflow
    logic pop;      // score top entry, fetch entry below
    logic update;   // fold product into best, install fetched top
    logic push;     // push latched bar
    logic finish;   // hand result to output register, clear histogram
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;     // bar count reached stack depth
    logic last;     // latched bar closes the histogram
    logic empty;    // stack holds no entries
    logic pop_hit;  // top entry is at least as tall as latched bar
    logic out_busy; // output register still holds an untaken result
  } sts_t;

endpackage

// ----- hw/rtl/hlr_ctrl.sv -----
// Sequencing state machine for the histogram rectangle block.
module hlr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hlr_pkg::sts_t sts_i,
  output hlr_pkg::cmd_t cmd_o
);
  import hlr_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CMP   = 5'b00010,
    ST_POPW  = 5'b00100,
    ST_FLUSH = 5'b01000,
    ST_FPOPW = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_CMP;
        end
      end
      ST_CMP: begin
        if (sts_i.full) begin
          cmd_o.ovf = 1'b1;
          state_d   = sts_i.last ? ST_FLUSH : ST_IDLE;
        end else if (sts_i.pop_hit) begin
          cmd_o.pop = 1'b1;
          state_d   = ST_POPW;
        end else begin
          cmd_o.push = 1'b1;
          state_d    = sts_i.last ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_POPW: begin
        cmd_o.update = 1'b1;
        state_d      = ST_CMP;
      end
      ST_FLUSH: begin
        if (!sts_i.empty) begin
          cmd_o.pop = 1'b1;
          state_d   = ST_FPOPW;
        end else if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_FPOPW: begin
        cmd_o.update = 1'b1;
        state_d      = ST_FLUSH;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hw/rtl/hlr_dp.sv -----
// Stack memory, cached top entry, area multiplier and result register.
module hlr_dp #(
  parameter int unsigned MAX_BARS = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [hlr_pkg::HEIGHT_W-1:0]    height_i,
  input  logic                            last_i,
  input  hlr_pkg::cmd_t                   cmd_i,
  output hlr_pkg::sts_t                   sts_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [hlr_pkg::AREA_W-1:0]      rect_area_o,
  output logic                            overflow_o
);
  import hlr_pkg::*;

  localparam int unsigned PW   = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
  localparam int unsigned CW   = $clog2(MAX_BARS + 1);
  localparam int unsigned PA_W = (HEIGHT_W + CW > AREA_W + 1) ? HEIGHT_W + CW : AREA_W + 1;
  localparam int unsigned EW   = PW + HEIGHT_W;

  // entry = {left start position, height}
  logic [EW-1:0]       mem [MAX_BARS];
  logic [EW-1:0]       rd_q;

  logic [HEIGHT_W-1:0] h_q;
  logic                last_q;
  logic [CW-1:0]       fill_q;
  logic [CW-1:0]       bar_count_q;
  logic [PW-1:0]       top_start_q;
  logic [HEIGHT_W-1:0] top_h_q;
  logic [PW-1:0]       pop_start_q;
  logic                popped_q;
  logic [PA_W-1:0]     prod_q;
  logic [AREA_W-1:0]   best_q;
  logic                ovf_q;
  logic                out_valid_q;
  logic [AREA_W-1:0]   rect_area_q;
  logic                overflow_q;

  logic [CW-1:0]       fill_m1;
  logic [CW-1:0]       fill_m2;
  logic [CW-1:0]       width;
  logic [PW-1:0]       start_new;
  logic [AREA_W-1:0]   area_sat;

  assign fill_m1   = fill_q - CW'(1);
  assign fill_m2   = fill_q - CW'(2);
  assign width     = bar_count_q - CW'(top_start_q);
  assign start_new = popped_q ? pop_start_q : bar_count_q[PW-1:0];
  assign area_sat  = (prod_q > PA_W'(AREA_MAX)) ? AREA_MAX : prod_q[AREA_W-1:0];

  assign sts_o.full     = (bar_count_q == CW'(MAX_BARS));
  assign sts_o.last     = last_q;
  assign sts_o.empty    = (fill_q == '0);
  assign sts_o.pop_hit  = (fill_q != '0) && (top_h_q >= h_q);
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign rect_area_o = rect_area_q;
  assign overflow_o  = overflow_q;

  // stack memory, entries below the cached top
  always_ff @(posedge clk_i) begin
    if (cmd_i.push && (fill_q != '0)) begin
      mem[fill_m1[PW-1:0]] <= {top_start_q, top_h_q};
    end
    if (cmd_i.pop) begin
      rd_q <= mem[fill_m2[PW-1:0]];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      h_q    <= height_i;
      last_q <= last_i;
    end
    if (cmd_i.pop) begin
      prod_q      <= PA_W'(top_h_q) * PA_W'(width);
      pop_start_q <= top_start_q;
    end
    if (cmd_i.update) begin
      {top_start_q, top_h_q} <= rd_q;
    end else if (cmd_i.push) begin
      top_start_q <= start_new;
      top_h_q     <= h_q;
    end
    if (cmd_i.finish) begin
      rect_area_q <= best_q;
      overflow_q  <= ovf_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      bar_count_q <= '0;
      popped_q    <= 1'b0;
      best_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.take) begin
        popped_q <= 1'b0;
      end else if (cmd_i.pop) begin
        popped_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        fill_q      <= '0;
        bar_count_q <= '0;
        best_q      <= '0;
        ovf_q       <= 1'b0;
      end else begin
        if (cmd_i.pop) begin
          fill_q <= fill_m1;
        end else if (cmd_i.push) begin
          fill_q      <= fill_q + CW'(1);
          bar_count_q <= bar_count_q + CW'(1);
        end
        if (cmd_i.update && (area_sat > best_q)) begin
          best_q <= area_sat;
        end
        if (cmd_i.ovf) begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_fill_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= bar_count_q)
    else $error("stack holds more entries than bars");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> fill_q != '0)
    else $error("pop from empty stack");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> bar_count_q < CW'(MAX_BARS))
    else $error("push beyond stack depth");

  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> (fill_q == '0) && (bar_count_q == '0) && out_valid_q)
    else $error("histogram state not cleared after result");
`endif

endmodule

// ----- hw/rtl/histogram_largest_rectangle.sv -----
// Top level of the largest-rectangle-in-histogram block.
// Bars arrive one request at a time on the input channel (height_i, last_i); a
// request with last_i set closes the histogram and, once the stack is flushed,
// yields one result request carrying rect_area_o and overflow_o, after which all
// histogram state is clear for the next one. Bars past MAX_BARS in a histogram
// are dropped and set overflow_o. Each bar is taken in ST_IDLE; in ST_CMP it is
// pushed, dropped, or pops a stack entry through ST_POPW and repeats. The
// closing bar then flushes each remaining entry through ST_FLUSH and ST_FPOPW
// before the result is loaded. A new bar is taken only once the previous bar,
// and any flush it starts, is done. Each bar is pushed and popped at most once;
// each pop waits on the registered stack memory read and the registered area
// multiplier. The result sits in an output register, so a new histogram can
// start while the previous result waits; only a second finished result stalls
// until the first is taken. The stack memory needs no clearing pass after reset.
module histogram_largest_rectangle #(
  parameter int unsigned MAX_BARS = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [hlr_pkg::HEIGHT_W-1:0] height_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [hlr_pkg::AREA_W-1:0]   rect_area_o,
  output logic                         overflow_o
);
  import hlr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // controller: accept, compare/pop loop, flush, result hand-off
  hlr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: stack, scoring, result register
  hlr_dp #(
    .MAX_BARS (MAX_BARS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .height_i    (height_i),
    .last_i      (last_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rect_area_o (rect_area_o),
    .overflow_o  (overflow_o)
  );

endmodule
